FILE: hdl/assert_macros.svh
// Assertion helper macros for the lexeme classifier RTL.
// Included by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Check that a condition leads to another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/ltc_pkg.sv
// Shared types, codes and lookup functions of the lexeme classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ltc_pkg;

  localparam logic [7:0] CH_TERM   = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_BOOLEAN = 3'd1;
  localparam logic [2:0] KIND_NULL    = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_NUMBER  = 3'd4;
  localparam logic [2:0] KIND_FLOAT   = 3'd5;
  localparam logic [2:0] KIND_IDENT   = 3'd6;
  localparam logic [2:0] KIND_SYMBOL  = 3'd7;

  localparam int KW_COUNT = 3;
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;
  localparam logic [2:0] KW_TRUE_LEN  = 3'd4;
  localparam logic [2:0] KW_FALSE_LEN = 3'd5;
  localparam logic [2:0] KW_NULL_LEN  = 3'd4;
  localparam logic [2:0] COUNT_MAX = 3'd7;

  typedef enum logic [2:0] {
    P_START,
    P_QUOTE,
    P_INT,
    P_DOT,
    P_IDENT,
    P_SETTLED
  } path_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } sym_t;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       term;
    logic       quote;
    logic       digit;
    logic       letter;
    logic       under;
    logic       dot;
    sym_t       sym;
  } item_t;

  // Position of a character in the fixed symbol table.
  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t r;
    r.hit = 1'b1;
    unique case (c)
      8'h2B: r.idx = 6'd0;   // +
      8'h2D: r.idx = 6'd1;   // -
      8'h2A: r.idx = 6'd2;   // *
      8'h2F: r.idx = 6'd3;   // /
      8'h25: r.idx = 6'd4;   // %
      8'h26: r.idx = 6'd5;   // &
      8'h7C: r.idx = 6'd6;   // |
      8'h5E: r.idx = 6'd7;   // ^
      8'h7E: r.idx = 6'd8;   // ~
      8'h3F: r.idx = 6'd9;   // ?
      8'h3A: r.idx = 6'd10;  // :
      8'h2E: r.idx = 6'd11;  // .
      8'h2C: r.idx = 6'd12;  // ,
      8'h3B: r.idx = 6'd13;  // ;
      8'h40: r.idx = 6'd14;  // @
      8'h24: r.idx = 6'd15;  // $
      8'h21: r.idx = 6'd16;  // !
      8'h3C: r.idx = 6'd17;  // <
      8'h3E: r.idx = 6'd18;  // >
      8'h3D: r.idx = 6'd19;  // =
      8'h23: r.idx = 6'd20;  // #
      8'h5C: r.idx = 6'd21;  // backslash
      8'h60: r.idx = 6'd22;  // backtick
      8'h22: r.idx = 6'd23;  // double quote
      8'h27: r.idx = 6'd24;  // single quote
      8'h5B: r.idx = 6'd25;  // [
      8'h5D: r.idx = 6'd26;  // ]
      8'h7B: r.idx = 6'd27;  // {
      8'h7D: r.idx = 6'd28;  // }
      8'h28: r.idx = 6'd29;  // (
      8'h29: r.idx = 6'd30;  // )
      8'h0A: r.idx = 6'd31;  // newline
      8'h09: r.idx = 6'd32;  // tab
      8'h0D: r.idx = 6'd33;  // carriage return
      8'h08: r.idx = 6'd34;  // backspace
      8'h0C: r.idx = 6'd35;  // form feed
      default: begin
        r.hit = 1'b0;
        r.idx = 6'd0;
      end
    endcase
    return r;
  endfunction

  // Expected character of a keyword at a position; zero past its end.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    unique case (k)
      KW_TRUE: begin
        unique case (pos)
          3'd0: r = 8'h74;
          3'd1: r = 8'h72;
          3'd2: r = 8'h75;
          3'd3: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      KW_FALSE: begin
        unique case (pos)
          3'd0: r = 8'h66;
          3'd1: r = 8'h61;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h73;
          3'd4: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      KW_NULL: begin
        unique case (pos)
          3'd0: r = 8'h6E;
          3'd1: r = 8'h75;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h6C;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] r;
    unique case (k)
      KW_TRUE:  r = KW_TRUE_LEN;
      KW_FALSE: r = KW_FALSE_LEN;
      KW_NULL:  r = KW_NULL_LEN;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/lexeme_type_classifier_unit.sv
// Top level of the lexeme type classifier: front decoder, queue, back end.
// Depends on ltc_pkg, ltc_front, ltc_queue, ltc_back and assert_macros.svh.
//
// Usage:
//   The slave stream carries one character per item in s_axis_tdata[7:0].
//   A zero character ends the lexeme; only that item produces a result on
//   the master stream: kind in m_axis_tdata[2:0] and the symbol table
//   position in m_axis_tdata[8:3] (zero unless kind is symbol).
//   Throughput: one character per cycle, sustained while the receiver takes
//   each result. The front decodes each character into a class record the
//   cycle it is accepted; the back state machine retires one record per
//   cycle from the queue, but a terminator waits at the queue head while a
//   result is pending. A terminator is registered in the queue, then retired
//   into the output register, which raises m_axis_tvalid with its result.
//   Reset: queue empty, lexeme state at start of lexeme, no result pending.
//   Receiver stall: the result holds in the output register. The back keeps
//   retiring plain characters; the next terminator waits at the queue head,
//   and s_axis_tready drops once QUEUE_DEPTH characters are waiting.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lexeme_type_classifier_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [2:0] kind, [8:3] symbol_index, rest zero
);
  import ltc_pkg::*;

  logic       push;
  item_t      push_item;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  item_t      head;
  logic [2:0] kind;
  logic [5:0] symbol_index;

  // Decode characters as they arrive.
  ltc_front u_front (
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_ch    (s_axis_tdata),
    .q_full  (q_full),
    .push    (push),
    .item    (push_item)
  );

  // Decouple decode from the lexeme state machine.
  ltc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Advance the lexeme state and register results.
  ltc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .m_valid        (m_axis_tvalid),
    .m_ready        (m_axis_tready),
    .m_kind         (kind),
    .m_symbol_index (symbol_index)
  );

  assign m_axis_tdata = {7'd0, symbol_index, kind};

  // A retired terminator always leaves a result in the output register.
  `ASSERT_NEXT(a_term_gives_result, clk, rst, pop && head.term, m_axis_tvalid)
  // Plain characters never wait at the queue head.
  `ASSERT_HOLDS(a_plain_retires, clk, rst, !(head_valid && !head.term) || pop)
  // Only a symbol result carries a table position.
  `ASSERT_HOLDS(a_sym_only_symbol, clk, rst,
    !(m_axis_tvalid && (kind != KIND_SYMBOL)) || (symbol_index == 6'd0))

endmodule

FILE: hdl/ltc_front.sv
// Front end: accepts input characters and decodes their character class.
// Depends on ltc_pkg.
`timescale 1ns / 1ps
module ltc_front (
  input  logic          s_valid,
  output logic          s_ready,
  input  logic [7:0]    s_ch,
  input  logic          q_full,
  output logic          push,
  output ltc_pkg::item_t item
);
  import ltc_pkg::*;

  assign s_ready = !q_full;
  assign push    = s_valid && !q_full;

  always_comb begin
    item.ch     = s_ch;
    item.term   = (s_ch == CH_TERM);
    item.quote  = (s_ch == CH_DQUOTE) || (s_ch == CH_SQUOTE);
    item.digit  = (s_ch >= 8'h30) && (s_ch <= 8'h39);
    item.letter = ((s_ch >= 8'h41) && (s_ch <= 8'h5A)) ||
                  ((s_ch >= 8'h61) && (s_ch <= 8'h7A));
    item.under  = (s_ch == CH_UNDER);
    item.dot    = (s_ch == CH_DOT);
    item.sym    = sym_lookup(s_ch);
  end

endmodule

FILE: hdl/ltc_queue.sv
// Small first-in first-out queue of classified characters.
// Depends on ltc_pkg for the item type.
`timescale 1ns / 1ps
module ltc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ltc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ltc_pkg::item_t head
);
  import ltc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/ltc_back.sv
// Back end: lexeme state machine and registered result stage.
// Depends on ltc_pkg.
`timescale 1ns / 1ps
module ltc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  ltc_pkg::item_t head,
  output logic           pop,
  output logic           m_valid,
  input  logic           m_ready,
  output logic [2:0]     m_kind,
  output logic [5:0]     m_symbol_index
);
  import ltc_pkg::*;

  path_t      path, path_next;
  logic [2:0] char_count, char_count_next;
  logic [2:0] kw_alive, kw_alive_next;
  logic       ident_clean, ident_clean_next;
  logic [7:0] open_quote, open_quote_next;
  logic [2:0] settled_kind, settled_kind_next;
  logic [5:0] settled_sym, settled_sym_next;

  logic [2:0] res_kind;
  logic [5:0] res_sym;
  logic       out_free;

  // Output and pop decision.
  always_comb begin
    out_free = !m_valid || m_ready;
    pop      = head_valid && (!head.term || out_free);
    res_kind = KIND_UNKNOWN;
    res_sym  = 6'd0;
    priority if (kw_alive[KW_TRUE] && (char_count == KW_TRUE_LEN)) begin
      res_kind = KIND_BOOLEAN;
    end else if (kw_alive[KW_FALSE] && (char_count == KW_FALSE_LEN)) begin
      res_kind = KIND_BOOLEAN;
    end else if (kw_alive[KW_NULL] && (char_count == KW_NULL_LEN)) begin
      res_kind = KIND_NULL;
    end else begin
      unique case (path)
        P_INT:     res_kind = KIND_NUMBER;
        P_IDENT:   res_kind = ident_clean ? KIND_IDENT : KIND_UNKNOWN;
        P_SETTLED: begin
          res_kind = settled_kind;
          res_sym  = settled_sym;
        end
        default:   res_kind = KIND_UNKNOWN;
      endcase
    end
  end

  // Next state.
  always_comb begin
    path_next         = path;
    char_count_next   = char_count;
    kw_alive_next     = kw_alive;
    ident_clean_next  = ident_clean;
    open_quote_next   = open_quote;
    settled_kind_next = settled_kind;
    settled_sym_next  = settled_sym;
    if (pop) begin
      if (head.term) begin
        path_next         = P_START;
        char_count_next   = 3'd0;
        kw_alive_next     = 3'b111;
        ident_clean_next  = 1'b1;
        open_quote_next   = 8'h00;
        settled_kind_next = KIND_UNKNOWN;
        settled_sym_next  = 6'd0;
      end else begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if ((char_count >= kw_len(2'(k))) || (kw_char(2'(k), char_count) != head.ch)) begin
            kw_alive_next[k] = 1'b0;
          end
        end
        if (char_count != COUNT_MAX) begin
          char_count_next = char_count + 3'd1;
        end
        unique case (path)
          P_START: begin
            priority if (head.quote) begin
              path_next       = P_QUOTE;
              open_quote_next = head.ch;
            end else if (head.digit) begin
              path_next = P_INT;
            end else if (head.letter) begin
              path_next = P_IDENT;
            end else begin
              path_next         = P_SETTLED;
              settled_kind_next = head.sym.hit ? KIND_SYMBOL : KIND_UNKNOWN;
              settled_sym_next  = head.sym.hit ? head.sym.idx : 6'd0;
            end
          end
          P_QUOTE: begin
            if (head.ch == open_quote) begin
              path_next         = P_SETTLED;
              settled_kind_next = KIND_STRING;
              settled_sym_next  = 6'd0;
            end
          end
          P_INT: begin
            priority if (head.dot) begin
              path_next = P_DOT;
            end else if (!head.digit) begin
              path_next         = P_SETTLED;
              settled_kind_next = KIND_NUMBER;
              settled_sym_next  = 6'd0;
            end else begin
              path_next = P_INT;
            end
          end
          P_DOT: begin
            path_next         = P_SETTLED;
            settled_kind_next = head.digit ? KIND_FLOAT : KIND_UNKNOWN;
            settled_sym_next  = 6'd0;
          end
          P_IDENT: begin
            if (!(head.letter || head.digit || head.under)) begin
              ident_clean_next = 1'b0;
            end
          end
          default: path_next = path;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path         <= P_START;
      char_count   <= 3'd0;
      kw_alive     <= 3'b111;
      ident_clean  <= 1'b1;
      open_quote   <= 8'h00;
      settled_kind <= KIND_UNKNOWN;
      settled_sym  <= 6'd0;
      m_valid      <= 1'b0;
    end else begin
      path         <= path_next;
      char_count   <= char_count_next;
      kw_alive     <= kw_alive_next;
      ident_clean  <= ident_clean_next;
      open_quote   <= open_quote_next;
      settled_kind <= settled_kind_next;
      settled_sym  <= settled_sym_next;
      if (pop && head.term) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on a terminator, hold otherwise.
  always_ff @(posedge clk) begin
    if (pop && head.term) begin
      m_kind         <= res_kind;
      m_symbol_index <= res_sym;
    end
  end

endmodule
